[rtl/mtra_pkg.sv]
// Shared constants, types and codes of the multitouch report aggregator.
package mtra_pkg;

    localparam int MAX_FINGERS = 10;
    localparam int IDX_W       = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
    localparam int CNT_W       = $clog2(MAX_FINGERS + 1);

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int NIB_W    = 4;
    localparam int DROP_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FLAG_DETECT   = 8'h80;
    localparam logic [BYTE_W-1:0] FLAG_PRESS    = 8'h40;
    localparam logic [BYTE_W-1:0] FLAG_RELEASE  = 8'h20;
    localparam logic [BYTE_W-1:0] FLAG_MOVE     = 8'h10;
    localparam logic [BYTE_W-1:0] FLAG_SUPPRESS = 8'h02;
    localparam logic [NIB_W-1:0]  NIBBLE_MASK   = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPORT_ID_BASE = 2'd0,
        CFG_X_DROP_BITS    = 2'd1,
        CFG_Y_DROP_BITS    = 2'd2
    } cfg_index_t;

    // One finger slot as it lives in the slot memory.
    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [BYTE_W-1:0] amp;
        logic [BYTE_W-1:0] wid;
    } slot_data_t;

    localparam int SLOT_DATA_W = $bits(slot_data_t);

    // One input message as latched at acceptance.
    typedef struct packed {
        logic [BYTE_W-1:0] status_flags;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] xy_low;
        logic [BYTE_W-1:0] touch_area;
        logic [BYTE_W-1:0] touch_amplitude;
        logic              end_of_burst;
    } msg_t;

    // One report word.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [BYTE_W-1:0] amplitude;
        logic [BYTE_W-1:0] width;
        logic              frame_end;
        logic              run_last;
    } rpt_word_t;

endpackage

[rtl/mtra_ifs.sv]
// Handshake interfaces for messages, reports and configuration writes.
interface mtra_msg_if;
    import mtra_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] report_id;
    logic [BYTE_W-1:0] status_flags;
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] xy_low;
    logic [BYTE_W-1:0] touch_area;
    logic [BYTE_W-1:0] touch_amplitude;
    logic              end_of_burst;

    modport source (output valid, report_id, status_flags, x_high, y_high, xy_low,
                    touch_area, touch_amplitude, end_of_burst, input ready);
    modport sink   (input valid, report_id, status_flags, x_high, y_high, xy_low,
                    touch_area, touch_amplitude, end_of_burst, output ready);
endinterface

interface mtra_rpt_if;
    import mtra_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [BYTE_W-1:0] amplitude;
    logic [BYTE_W-1:0] width;
    logic              frame_end;
    logic              run_last;

    modport source (output valid, slot, pos_x, pos_y, amplitude, width, frame_end,
                    run_last, input ready);
    modport sink   (input valid, slot, pos_x, pos_y, amplitude, width, frame_end,
                    run_last, output ready);
endinterface

interface mtra_cfg_if;
    import mtra_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mtra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mtra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/multitouch_report_aggregator.sv]
// Top level of the multitouch report aggregator: slot memory, sequencer and report staging.
//
//   channel   modport   direction   word
//   msg       sink      in          one seven-byte touch message plus end_of_burst
//   rpt       source    out         one finger report (slot, position, amplitude, width)
//   cfg       sink      in          register write: index and 8-bit data, always ready
//
// A message that causes no flush reads its slot, writes it back, checks for the end of
// burst and finishes; one whose id is out of range skips the read and the write. A
// flush visits every finger slot, reads each active one and then closes the frame.
// A message may flush twice, once before its update and once at the end of burst.
// Reset clears the active, written and pending bits at once; the slot memory needs
// no clearing pass because a never-written slot reads as zero. Report stalls stall
// the flush walk, but a finished message frees msg.ready while its last word still
// waits in the output register.
module multitouch_report_aggregator (
    input  logic        clk,
    input  logic        rst_n,
    mtra_msg_if.sink    msg,
    mtra_rpt_if.source  rpt,
    mtra_cfg_if.sink    cfg
);
    import mtra_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_RD   = 7'b0000010,
        S_UP_WR   = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_FL_ADDR = 7'b0010000,
        S_FL_DATA = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    // Control state.
    state_t                   state_reg, state_next;
    logic [MAX_FINGERS-1:0]   active_reg, active_next;
    logic [MAX_FINGERS-1:0]   written_reg, written_next;
    logic [MAX_FINGERS-1:0]   pending_reg, pending_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     second_reg, second_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]        id_base_reg, id_base_next;
    logic [DROP_W-1:0]        x_drop_reg, x_drop_next;
    logic [DROP_W-1:0]        y_drop_reg, y_drop_next;

    // Payload.
    msg_t                     item_reg, item_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    rpt_word_t                hold_reg, hold_next;
    rpt_word_t                out_reg, out_next;

    // Slot memory port signals.
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    slot_data_t               ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    slot_data_t               ram_rd_data;

    // Decode helpers.
    logic [BYTE_W:0]          id_diff;
    logic                     id_ok;
    logic                     can_push;
    logic [IDX_W-1:0]         walk_idx;
    slot_data_t               old_slot;
    slot_data_t               new_slot;
    logic                     is_release;
    logic                     is_detect;
    logic                     is_suppress;
    logic                     do_update;
    logic [POS_W-1:0]         raw_x;
    logic [POS_W-1:0]         raw_y;

    // The slot memory holds position, amplitude and width. Each entry is read in the
    // cycle before it is written back, and the sequencer never issues a read of an
    // entry in the same cycle that writes it, so no forwarding path is needed.
    mtra_ram #(
        .WIDTH (SLOT_DATA_W),
        .DEPTH (MAX_FINGERS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign msg.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rpt.valid     = out_valid_reg;
    assign rpt.slot      = out_reg.slot;
    assign rpt.pos_x     = out_reg.pos_x;
    assign rpt.pos_y     = out_reg.pos_y;
    assign rpt.amplitude = out_reg.amplitude;
    assign rpt.width     = out_reg.width;
    assign rpt.frame_end = out_reg.frame_end;
    assign rpt.run_last  = out_reg.run_last;

    // The output register can take a word when it is empty or being drained.
    assign can_push = !out_valid_reg || rpt.ready;

    // The report id selects a slot when it lies in base .. base + MAX_FINGERS - 1.
    assign id_diff = {1'b0, msg.report_id} - {1'b0, id_base_reg};
    assign id_ok   = !id_diff[BYTE_W] && (id_diff[BYTE_W-1:0] < BYTE_W'(MAX_FINGERS));

    assign walk_idx = cnt_reg[IDX_W-1:0];

    // Slot update from the latched message. A slot never written reads as zero.
    assign raw_x = {item_reg.x_high, item_reg.xy_low[BYTE_W-1:NIB_W]};
    assign raw_y = {item_reg.y_high, item_reg.xy_low[NIB_W-1:0] & NIBBLE_MASK};

    assign is_release  = (item_reg.status_flags & FLAG_RELEASE) != '0;
    assign is_detect   = ((item_reg.status_flags & FLAG_DETECT) != '0)
                      && ((item_reg.status_flags & (FLAG_PRESS | FLAG_MOVE)) != '0);
    assign is_suppress = ((item_reg.status_flags & FLAG_SUPPRESS) != '0)
                      && active_reg[idx_reg];
    assign do_update   = is_release || is_detect || is_suppress;

    always_comb
    begin
        old_slot = written_reg[idx_reg] ? ram_rd_data : '0;
        new_slot = old_slot;
        if (is_release)
        begin
            new_slot.amp = '0;
            new_slot.wid = item_reg.touch_area;
        end
        else if (is_detect)
        begin
            new_slot.amp = item_reg.touch_amplitude;
            new_slot.wid = item_reg.touch_area;
            new_slot.x   = raw_x >> x_drop_reg;
            new_slot.y   = raw_y >> y_drop_reg;
        end
        else if (is_suppress)
        begin
            new_slot.amp = '0;
            new_slot.wid = item_reg.touch_area;
        end
    end

    // The user must send configuration writes only while no message is in flight; the block does not enforce it.
    always_comb
    begin
        id_base_next = id_base_reg;
        x_drop_next  = x_drop_reg;
        y_drop_next  = y_drop_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_REPORT_ID_BASE: id_base_next = cfg.data;
                CFG_X_DROP_BITS:    x_drop_next  = cfg.data[DROP_W-1:0];
                CFG_Y_DROP_BITS:    y_drop_next  = cfg.data[DROP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer. A flush walks the slots in ascending order; each report first
    // sits in the hold register so that the flush end and the message end can be
    // marked on it before it moves to the output register.
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        written_next    = written_reg;
        pending_next    = pending_reg;
        cnt_next        = cnt_reg;
        second_next     = second_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rpt.ready;

        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = new_slot;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    item_next.status_flags    = msg.status_flags;
                    item_next.x_high          = msg.x_high;
                    item_next.y_high          = msg.y_high;
                    item_next.xy_low          = msg.xy_low;
                    item_next.touch_area      = msg.touch_area;
                    item_next.touch_amplitude = msg.touch_amplitude;
                    item_next.end_of_burst    = msg.end_of_burst;
                    idx_next                  = id_diff[IDX_W-1:0];
                    hold_valid_next           = 1'b0;
                    cnt_next                  = '0;
                    if (!id_ok)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (pending_reg[id_diff[IDX_W-1:0]])
                    begin
                        // The slot already has an update in this frame: flush first.
                        second_next = 1'b0;
                        state_next  = S_FL_ADDR;
                    end
                    else
                    begin
                        state_next = S_UP_RD;
                    end
                end
            end

            S_UP_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                if (do_update)
                begin
                    ram_wr_en             = 1'b1;
                    written_next[idx_reg] = 1'b1;
                    pending_next[idx_reg] = 1'b1;
                    if (is_release || is_detect)
                    begin
                        active_next[idx_reg] = 1'b1;
                    end
                end
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (item_reg.end_of_burst && (pending_reg != '0))
                begin
                    second_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_FL_ADDR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FL_ADDR:
            begin
                if (cnt_reg == CNT_W'(MAX_FINGERS))
                begin
                    // A pending slot is active, so the flush left a word in hold.
                    hold_next.frame_end = 1'b1;
                    pending_next        = '0;
                    state_next          = second_reg ? S_DONE : S_UP_RD;
                end
                else if (!active_reg[walk_idx])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = walk_idx;
                    state_next  = S_FL_DATA;
                end
            end

            S_FL_DATA:
            begin
                if (!hold_valid_reg || can_push)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_valid_next = 1'b1;
                    end
                    hold_valid_next     = 1'b1;
                    hold_next.slot      = SLOT_W'(walk_idx);
                    hold_next.pos_x     = ram_rd_data.x;
                    hold_next.pos_y     = ram_rd_data.y;
                    hold_next.amplitude = ram_rd_data.amp;
                    hold_next.width     = ram_rd_data.wid;
                    hold_next.frame_end = 1'b0;
                    hold_next.run_last  = 1'b0;
                    if (ram_rd_data.amp == '0)
                    begin
                        active_next[walk_idx] = 1'b0;
                    end
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FL_ADDR;
                end
            end

            S_DONE:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    out_next          = hold_reg;
                    out_next.run_last = 1'b1;
                    out_valid_next    = 1'b1;
                    hold_valid_next   = 1'b0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            written_reg    <= '0;
            pending_reg    <= '0;
            cnt_reg        <= '0;
            second_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            id_base_reg    <= '0;
            x_drop_reg     <= '0;
            y_drop_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            written_reg    <= written_next;
            pending_reg    <= pending_next;
            cnt_reg        <= cnt_next;
            second_reg     <= second_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            id_base_reg    <= id_base_next;
            x_drop_reg     <= x_drop_next;
            y_drop_reg     <= y_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/mtra_checker.sv]
// Port-level assertions for the multitouch report aggregator and their binding.
module mtra_checker (
    input logic clk,
    input logic rst_n,
    input logic msg_valid,
    input logic msg_ready,
    input logic rpt_valid,
    input logic rpt_ready,
    input logic [3:0] rpt_slot,
    input logic [11:0] rpt_pos_x,
    input logic [7:0] rpt_amplitude,
    input logic rpt_frame_end,
    input logic rpt_run_last
);
    import mtra_pkg::*;

    // A stalled report word holds still.
    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_slot)
            && $stable(rpt_pos_x) && $stable(rpt_amplitude))
        else $error("report word changed while stalled");

    // Only existing finger slots are reported.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> (rpt_slot < SLOT_W'(MAX_FINGERS)))
        else $error("report names a slot beyond the finger count");

    // The last word of a message always closes a frame.
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_run_last |-> rpt_frame_end)
        else $error("message ended in the middle of a frame");

    // One message at a time: acceptance closes the input until it is processed.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |=> !msg_ready)
        else $error("input accepted again right after a message");

endmodule

bind multitouch_report_aggregator mtra_checker u_mtra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .msg_valid     (msg.valid),
    .msg_ready     (msg.ready),
    .rpt_valid     (rpt.valid),
    .rpt_ready     (rpt.ready),
    .rpt_slot      (rpt.slot),
    .rpt_pos_x     (rpt.pos_x),
    .rpt_amplitude (rpt.amplitude),
    .rpt_frame_end (rpt.frame_end),
    .rpt_run_last  (rpt.run_last)
);

[dv/multitouch_report_aggregator_test.sv]
// Self-checking testbench for the multitouch report aggregator: finger slot prediction, checks.
module multitouch_report_aggregator_test;

    import mtra_pkg::*;

    // Cycles allowed after the last expected report before the next register write
    // or the end of the run. A message that reports nothing can still be busy in
    // the sequencer after that.
    localparam int SETTLE_CYCLES = 40;
    // Length of the one long report hold-off that backs up the message input.
    localparam int LONG_HOLD     = 400;
    // Timeout for the whole run, well above the slowest correct run.
    localparam int LIMIT_CYCLES  = 250000;
    localparam int SHOWN_ERRORS  = 10;

    // One touch controller message as the sender offers it.
    typedef struct packed {
        logic [BYTE_W-1:0] report_id;
        logic [BYTE_W-1:0] status_flags;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] xy_low;
        logic [BYTE_W-1:0] touch_area;
        logic [BYTE_W-1:0] touch_amplitude;
        logic              end_of_burst;
    } touch_msg_t;

    // The predictor's own view of one finger slot.
    typedef struct {
        logic              active;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [BYTE_W-1:0] amp;
        logic [BYTE_W-1:0] wid;
    } finger_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mtra_msg_if msg_if ();
    mtra_rpt_if rpt_if ();
    mtra_cfg_if cfg_if ();

    multitouch_report_aggregator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if.sink),
        .rpt   (rpt_if.source),
        .cfg   (cfg_if.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted finger state and the register copies it works from.
    finger_t                fingers [MAX_FINGERS];
    logic [MAX_FINGERS-1:0] pending_slots;
    logic [BYTE_W-1:0]      id_base;
    logic [DROP_W-1:0]      x_shift;
    logic [DROP_W-1:0]      y_shift;

    // Messages waiting for the sender, and reports waiting for the block.
    touch_msg_t queued_msgs [$];
    rpt_word_t  expected_reports [$];

    // Sender and receiver pacing, set per phase by the stimulus process.
    int stall_pct     = 0;
    bit sender_gaps   = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int burst_left    = 0;
    int idle_left     = 0;
    logic msg_taken   = 1'b0;
    touch_msg_t upcoming;

    // Run bookkeeping.
    int   cycle_count  = 0;
    int   fail_count   = 0;
    int   msg_count    = 0;
    int   report_count = 0;
    int   frame_count  = 0;
    rpt_word_t seen;
    rpt_word_t want;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Emits every active slot in ascending order; lifted fingers (amplitude
    // zero) are reported once more and then dropped from the frame.
    function automatic void flush_frame();
        rpt_word_t w;
        int        first;
        first = expected_reports.size();
        for (int i = 0; i < MAX_FINGERS; i++)
        begin
            if (fingers[i].active)
            begin
                w.slot      = i[SLOT_W-1:0];
                w.pos_x     = fingers[i].x;
                w.pos_y     = fingers[i].y;
                w.amplitude = fingers[i].amp;
                w.width     = fingers[i].wid;
                w.frame_end = 1'b0;
                w.run_last  = 1'b0;
                expected_reports.push_back(w);
                if (fingers[i].amp == '0)
                    fingers[i].active = 1'b0;
            end
        end
        if (expected_reports.size() > first)
        begin
            expected_reports[expected_reports.size()-1].frame_end = 1'b1;
            frame_count++;
        end
        pending_slots = '0;
    endfunction

    // Applies one accepted message to the predicted slots and queues the
    // reports it causes.
    function automatic void predict_message(input touch_msg_t m);
        int slot_idx;
        int first;
        first    = expected_reports.size();
        slot_idx = int'(m.report_id) - int'(id_base);
        if (slot_idx >= 0 && slot_idx < MAX_FINGERS)
        begin
            // A second update to a slot that is still pending closes the frame first.
            if (pending_slots[slot_idx])
                flush_frame();
            if ((m.status_flags & FLAG_RELEASE) != '0)
            begin
                // Release wins over every other flag; position is kept.
                fingers[slot_idx].amp    = '0;
                fingers[slot_idx].wid    = m.touch_area;
                fingers[slot_idx].active = 1'b1;
                pending_slots[slot_idx]  = 1'b1;
            end
            else if ((m.status_flags & FLAG_DETECT) != '0 &&
                     (m.status_flags & (FLAG_PRESS | FLAG_MOVE)) != '0)
            begin
                fingers[slot_idx].amp    = m.touch_amplitude;
                fingers[slot_idx].wid    = m.touch_area;
                fingers[slot_idx].x      = {m.x_high, m.xy_low[7:4]} >> x_shift;
                fingers[slot_idx].y      = {m.y_high, m.xy_low[3:0]} >> y_shift;
                fingers[slot_idx].active = 1'b1;
                pending_slots[slot_idx]  = 1'b1;
            end
            else if ((m.status_flags & FLAG_SUPPRESS) != '0 && fingers[slot_idx].active)
            begin
                fingers[slot_idx].amp   = '0;
                fingers[slot_idx].wid   = m.touch_area;
                pending_slots[slot_idx] = 1'b1;
            end
        end
        // End of burst flushes whatever is pending, even for an ignored id.
        if (m.end_of_burst && pending_slots != '0)
            flush_frame();
        if (expected_reports.size() > first)
            expected_reports[expected_reports.size()-1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Message driver: bursts of random length, separated by random gaps when
    // the phase asks for them. A word is held until the block takes it; inputs
    // change at the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!msg_if.valid || msg_taken)
        begin
            if (idle_left > 0)
            begin
                idle_left    <= idle_left - 1;
                msg_if.valid <= 1'b0;
            end
            else if (queued_msgs.size() != 0)
            begin
                upcoming = queued_msgs.pop_front();
                msg_if.report_id       <= upcoming.report_id;
                msg_if.status_flags    <= upcoming.status_flags;
                msg_if.x_high          <= upcoming.x_high;
                msg_if.y_high          <= upcoming.y_high;
                msg_if.xy_low          <= upcoming.xy_low;
                msg_if.touch_area      <= upcoming.touch_area;
                msg_if.touch_amplitude <= upcoming.touch_amplitude;
                msg_if.end_of_burst    <= upcoming.end_of_burst;
                msg_if.valid           <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    idle_left  <= sender_gaps ? $urandom_range(1, 6) : 0;
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                msg_if.valid <= 1'b0;
            end
        end
    end

    // Long hold-off timer. It runs in its own process so that the sender keeps
    // offering words while reports are blocked and the block backs up.
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_requests != holds_done)
        begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end
    end

    // Report receiver: short random stall runs whose density the phase sets,
    // overridden by the long hold-off while it lasts.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            rpt_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rpt_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left   <= $urandom_range(0, 7);
            rpt_if.ready <= 1'b0;
        end
        else
        begin
            rpt_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted message word and checks every
    // accepted report word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d reports still expected",
                     cycle_count, expected_reports.size());
            $display("simulation failed");
            $finish;
        end
        if (rst_n)
        begin
            msg_taken <= msg_if.valid && msg_if.ready;
            if (rpt_if.valid && rpt_if.ready)
            begin
                seen.slot      = rpt_if.slot;
                seen.pos_x     = rpt_if.pos_x;
                seen.pos_y     = rpt_if.pos_y;
                seen.amplitude = rpt_if.amplitude;
                seen.width     = rpt_if.width;
                seen.frame_end = rpt_if.frame_end;
                seen.run_last  = rpt_if.run_last;
                report_count++;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("report with nothing expected: slot %0d x %0d y %0d",
                                 seen.slot, seen.pos_x, seen.pos_y);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.slot !== want.slot || seen.pos_x !== want.pos_x ||
                        seen.pos_y !== want.pos_y || seen.amplitude !== want.amplitude ||
                        seen.width !== want.width || seen.frame_end !== want.frame_end ||
                        seen.run_last !== want.run_last)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_ERRORS)
                        begin
                            $display("report %0d mismatch (slot x y amp wid fe rl)",
                                     report_count);
                            $display("  expected %0d %0d %0d %0d %0d %0d %0d",
                                     want.slot, want.pos_x, want.pos_y, want.amplitude,
                                     want.width, want.frame_end, want.run_last);
                            $display("  actual   %0d %0d %0d %0d %0d %0d %0d",
                                     seen.slot, seen.pos_x, seen.pos_y, seen.amplitude,
                                     seen.width, seen.frame_end, seen.run_last);
                        end
                    end
                end
            end
            if (msg_if.valid && msg_if.ready)
            begin
                msg_count++;
                predict_message('{msg_if.report_id, msg_if.status_flags, msg_if.x_high,
                                  msg_if.y_high, msg_if.xy_low, msg_if.touch_area,
                                  msg_if.touch_amplitude, msg_if.end_of_burst});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic touch_msg_t make_msg(input logic [7:0] rid, input logic [7:0] flags,
                                            input logic [11:0] x, input logic [11:0] y,
                                            input logic [7:0] area, input logic [7:0] amp,
                                            input logic eob);
        touch_msg_t m;
        m.report_id       = rid;
        m.status_flags    = flags;
        m.x_high          = x[11:4];
        m.y_high          = y[11:4];
        m.xy_low          = {x[3:0], y[3:0]};
        m.touch_area      = area;
        m.touch_amplitude = amp;
        m.end_of_burst    = eob;
        return m;
    endfunction

    // Mostly well-formed finger traffic around the current base; the rest is
    // stray ids and arbitrary status bytes.
    function automatic touch_msg_t random_touch(input logic [7:0] base);
        touch_msg_t m;
        int         pick;
        m.x_high          = 8'($urandom);
        m.y_high          = 8'($urandom);
        m.xy_low          = 8'($urandom);
        m.touch_area      = 8'($urandom);
        m.touch_amplitude = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
        m.end_of_burst    = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 8)
            m.report_id = 8'($urandom);
        else
            m.report_id = base + 8'($urandom_range(0, MAX_FINGERS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            m.status_flags = 8'($urandom);
        else if (pick < 30)
            m.status_flags = FLAG_RELEASE;
        else if (pick < 55)
            m.status_flags = FLAG_DETECT | FLAG_PRESS;
        else if (pick < 75)
            m.status_flags = FLAG_DETECT | FLAG_MOVE;
        else if (pick < 85)
            m.status_flags = FLAG_DETECT | FLAG_PRESS | FLAG_MOVE;
        else
            m.status_flags = FLAG_SUPPRESS;
        // Sprinkle the flag bits that carry no meaning.
        if ($urandom_range(0, 3) == 0)
            m.status_flags = m.status_flags | (8'($urandom) & 8'h0D);
        return m;
    endfunction

    // Waits until the sender is drained and every expected report has come,
    // then lets a message that reports nothing finish.
    task automatic wait_idle();
        while (queued_msgs.size() != 0 || msg_if.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_REPORT_ID_BASE: id_base = value;
            CFG_X_DROP_BITS:    x_shift = value[DROP_W-1:0];
            CFG_Y_DROP_BITS:    y_shift = value[DROP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [7:0] base, input logic [1:0] xd,
                                input logic [1:0] yd, input int count, input int stall,
                                input bit gaps, input bit long_hold);
        write_reg(CFG_REPORT_ID_BASE, base);
        write_reg(CFG_X_DROP_BITS, {6'b0, xd});
        write_reg(CFG_Y_DROP_BITS, {6'b0, yd});
        @(posedge clk);
        stall_pct   = stall;
        sender_gaps = gaps;
        for (int k = 0; k < count; k++)
            queued_msgs.push_back(random_touch(base));
        if (long_hold)
            hold_requests++;
        wait_idle();
    endtask

    initial
    begin
        msg_if.valid           = 1'b0;
        msg_if.report_id       = '0;
        msg_if.status_flags    = '0;
        msg_if.x_high          = '0;
        msg_if.y_high          = '0;
        msg_if.xy_low          = '0;
        msg_if.touch_area      = '0;
        msg_if.touch_amplitude = '0;
        msg_if.end_of_burst    = 1'b0;
        rpt_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = CFG_REPORT_ID_BASE;
        cfg_if.data            = '0;
        for (int i = 0; i < MAX_FINGERS; i++)
            fingers[i] = '{1'b0, '0, '0, '0, '0};
        pending_slots = '0;
        id_base       = '0;
        x_shift       = '0;
        y_shift       = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: corner positions, every status
        // kind, the conflict flush, lifted fingers and a twenty-report message.
        stall_pct   = 30;
        sender_gaps = 1'b1;
        queued_msgs.push_back(make_msg(8'd0, FLAG_DETECT | FLAG_PRESS, 12'hFFF, 12'hFFF,
                                       8'hFF, 8'hFF, 1'b0));
        queued_msgs.push_back(make_msg(8'd9, FLAG_DETECT | FLAG_MOVE, 12'h000, 12'h000,
                                       8'h00, 8'h01, 1'b1));
        // Move without detect changes nothing.
        queued_msgs.push_back(make_msg(8'd0, FLAG_MOVE, 12'h123, 12'h456, 8'h01, 8'h02, 1'b0));
        queued_msgs.push_back(make_msg(8'd0, FLAG_RELEASE, 12'h000, 12'h000,
                                       8'h55, 8'h00, 1'b0));
        // Same slot again while pending: flush before and after the update.
        queued_msgs.push_back(make_msg(8'd0, FLAG_DETECT | FLAG_PRESS, 12'h800, 12'h001,
                                       8'h0F, 8'h80, 1'b1));
        // Detect with zero amplitude is reported once and then dropped.
        queued_msgs.push_back(make_msg(8'd3, FLAG_DETECT | FLAG_PRESS, 12'hA5A, 12'h5A5,
                                       8'h33, 8'h00, 1'b0));
        // An id beyond the slots is ignored, but its end of burst still flushes.
        queued_msgs.push_back(make_msg(8'd200, FLAG_DETECT | FLAG_PRESS, 12'h111, 12'h222,
                                       8'h44, 8'h66, 1'b1));
        // Suppress of an empty slot acts like an unknown status.
        queued_msgs.push_back(make_msg(8'd5, FLAG_SUPPRESS, 12'h321, 12'h654,
                                       8'h12, 8'h34, 1'b1));
        queued_msgs.push_back(make_msg(8'd9, FLAG_SUPPRESS, 12'h777, 12'h888,
                                       8'h07, 8'h99, 1'b1));
        // All flags at once: release takes priority.
        queued_msgs.push_back(make_msg(8'd2, 8'hFF, 12'hFFF, 12'hFFF, 8'hAA, 8'hFF, 1'b1));
        // Detect alone, with neither press nor move, is ignored.
        queued_msgs.push_back(make_msg(8'd4, FLAG_DETECT, 12'h0F0, 12'h0F0,
                                       8'h10, 8'h20, 1'b1));
        for (int i = 0; i < MAX_FINGERS; i++)
            queued_msgs.push_back(make_msg(i[7:0], FLAG_DETECT | FLAG_PRESS, 12'($urandom),
                                           12'($urandom), 8'($urandom), 8'($urandom), 1'b0));
        // Ten fingers pending, then slot zero again with end of burst: two full frames.
        queued_msgs.push_back(make_msg(8'd0, FLAG_DETECT | FLAG_MOVE, 12'h5A5, 12'hA5A,
                                       8'h3C, 8'hC3, 1'b1));
        wait_idle();

        // Random part over several register settings, the extremes included.
        random_phase(8'd255, 2'd3, 2'd3, 30, 25, 1'b1, 1'b0);
        random_phase(8'd100, 2'd1, 2'd2, 35, 20, 1'b1, 1'b1);
        random_phase(8'd246, 2'd2, 2'd1, 35, 40, 1'b1, 1'b0);
        random_phase(8'd0,   2'd0, 2'd3, 30, 0,  1'b0, 1'b0);
        random_phase(8'($urandom), 2'($urandom), 2'($urandom), 28, 15, 1'b1, 1'b0);

        fail_count = fail_count + expected_reports.size();
        $display("covered %0d messages, %0d reports in %0d frames, over six register",
                 msg_count, report_count, frame_count);
        $display("settings with a long report hold-off and %0d failures", fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
